// ===== rtl/fke_pkg.sv =====
// Package for the FASTA k-mer extractor: field widths, character codes,
// base encoding function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fke_pkg;

  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned KLEN_W      = 6;
  localparam int unsigned KMER_W      = 64;
  localparam int unsigned KMER_MAX    = 32;
  localparam int unsigned DATA_IN_W   = 8;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd16;
  localparam logic [KLEN_W-1:0] KLEN_MAX   = 6'd32;
  localparam logic [KLEN_W-1:0] KLEN_MIN   = 6'd1;

  localparam logic [TEXT_W-1:0] CH_HEADER = 8'h3E;  // '>'
  localparam logic [TEXT_W-1:0] CH_LF     = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
  localparam logic [TEXT_W-1:0] CH_A      = 8'h41;
  localparam logic [TEXT_W-1:0] CH_C      = 8'h43;
  localparam logic [TEXT_W-1:0] CH_T      = 8'h54;
  localparam logic [TEXT_W-1:0] CH_G      = 8'h47;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_T = 2'd2;
  localparam logic [1:0] BASE_G = 2'd3;

  // Map a character to its 2-bit base code; anything unknown reads as A.
  function automatic logic [1:0] base_code(input logic [TEXT_W-1:0] ch);
    logic [1:0] code;
    case (ch)
      CH_A:    code = BASE_A;
      CH_C:    code = BASE_C;
      CH_T:    code = BASE_T;
      CH_G:    code = BASE_G;
      default: code = BASE_A;
    endcase
    return code;
  endfunction

  // Clamp the programmed length into 1..32.
  function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] klen);
    logic [KLEN_W-1:0] k;
    if (klen == '0) begin
      k = KLEN_MIN;
    end else if (klen > KLEN_MAX) begin
      k = KLEN_MAX;
    end else begin
      k = klen;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fasta_kmer_extractor_top.sv =====
// FASTA k-mer extractor top level: input register, line state, result register.
// Depends on fke_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Streams FASTA text in one byte per request and emits packed DNA k-mers,
// two bits per base (A=0, C=1, T=2, G=3, anything else as 0), newest base
// in bits 1:0, masked to k bases. A newline or carriage return clears the
// line state; '>' skips the rest of its line; tlast on a byte clears all
// line state after that byte is handled. One byte is taken every cycle
// unless a byte is held and cannot be processed: the byte is held in an
// input register, then the window shift, mask and count update run
// combinationally into the result register. The result register lets the
// next byte be processed while a k-mer still waits, as long as the sink
// takes it in the same cycle; the input register holds a byte in a sink stall.
// kmer_length (cfg port, reset 16) is clamped to 1..32 and must only be
// written while the block is idle.
module fasta_kmer_extractor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write: kmer_length
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [5:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic        s_axis_tlast_i,   // end_of_buffer
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o    // [63:0] kmer_code
);

  localparam int unsigned TW = fke_pkg::TEXT_W;
  localparam int unsigned KW = fke_pkg::KLEN_W;
  localparam int unsigned WW = fke_pkg::KMER_W;

  // configuration
  logic [KW-1:0] klen_q;

  // input register
  logic          in_vld_q;
  logic [TW-1:0] in_byte_q;
  logic          in_last_q;

  // line state
  logic [WW-1:0] base_window_q, base_window_d;
  logic [KW-1:0] bases_seen_q, bases_seen_d;
  logic          in_header_q, in_header_d;

  // result register
  logic          out_vld_q, out_vld_d;
  logic [WW-1:0] out_data_q;

  logic          fire;
  logic          produced;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] seen_inc;
  logic [WW-1:0] win_mask;
  logic [WW-1:0] shifted;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= fke_pkg::KLEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      klen_q <= cfg_data_i;
    end
  end

  // Process the held byte when the result slot is free or being drained.
  assign fire            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Mask keeps the lowest 2k bits.
  assign k_eff = fke_pkg::eff_k(klen_q);
  always_comb begin
    for (int i = 0; i < WW / 2; i++) begin
      win_mask[2*i +: 2] = {2{(i < int'(k_eff))}};
    end
  end

  assign shifted  = {base_window_q[WW-3:0], fke_pkg::base_code(in_byte_q)} & win_mask;
  assign seen_inc = (bases_seen_q >= k_eff) ? k_eff : bases_seen_q + KW'(1);

  always_comb begin
    base_window_d = base_window_q;
    bases_seen_d  = bases_seen_q;
    in_header_d   = in_header_q;
    produced      = 1'b0;
    if (in_byte_q == fke_pkg::CH_LF || in_byte_q == fke_pkg::CH_CR) begin
      base_window_d = '0;
      bases_seen_d  = '0;
      in_header_d   = 1'b0;
    end else if (!in_header_q) begin
      if (in_byte_q == fke_pkg::CH_HEADER) begin
        in_header_d = 1'b1;
      end else begin
        base_window_d = shifted;
        bases_seen_d  = seen_inc;
        produced      = (seen_inc >= k_eff);
      end
    end
    // end of buffer: drop all line state after the byte is handled
    if (in_last_q) begin
      base_window_d = '0;
      bases_seen_d  = '0;
      in_header_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_window_q <= '0;
      bases_seen_q  <= '0;
      in_header_q   <= 1'b0;
    end else if (fire) begin
      base_window_q <= base_window_d;
      bases_seen_q  <= bases_seen_d;
      in_header_q   <= in_header_d;
    end
  end

  // Result slot: load on a producing byte, otherwise hold until taken.
  assign out_vld_d = fire ? produced : (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produced) begin
      out_data_q <= shifted;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // The base count never exceeds the longest k-mer.
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bases_seen_q <= fke_pkg::KLEN_MAX)
    else $error("bases_seen exceeds maximum k");

  // A producing byte always lands a k-mer in the result slot.
  a_produce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && produced |=> m_axis_tvalid_o)
    else $error("produced k-mer not presented");

  // End of buffer leaves the line state cleared.
  a_eob_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> (bases_seen_q == '0) && !in_header_q && (base_window_q == '0))
    else $error("line state not cleared after end of buffer");

  // Backpressure on the input only while a byte is held.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q && out_vld_q)
    else $error("input stalled without a held byte");
`endif

endmodule

`default_nettype wire
